### src/skct_pkg.sv
// Shared types and constants for the signed key counter table.
package skct_pkg;

  localparam int NUM_KEYS = 256;
  localparam int IDX_W    = $clog2(NUM_KEYS);
  localparam int NPOS_W   = $clog2(NUM_KEYS + 1);
  localparam int CNT_W    = 32;

  typedef struct packed {
    logic [7:0]         key;
    logic signed [15:0] delta;
    logic               batch_last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] key_count;
    logic [8:0]         positive_keys;
    logic               any_positive;
    logic [7:0]         max_positive_key;
    logic [30:0]        max_count;
    logic               batch_end;
  } out_t;

endpackage

### src/skct_ram.sv
// Generic single-port RAM with registered read data.
module skct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/signed_key_counter_table.sv
// Top level of the signed key counter table: update sequencer and table scan.
// Each transfer adds a signed delta to one saturating 32-bit counter held in a
// single-port RAM, then reads the whole table back one entry per cycle through
// one shared compare unit to build the summary (positive count, highest
// positive key, largest count floored at zero). An item runs through these
// steps in order: the transfer cycle, which reads the addressed counter, a
// write of the saturated sum, a read of every entry for the scan, a drain of
// the last read and the load of the result register; the single RAM port
// forces this order. The sequencer is idle again in the cycle in which the
// result becomes valid. A stalled result holds the sequencer in the load
// step until the output register is free. The next item is taken once
// the sequencer is idle, even while the previous result still waits in the
// output register. Counters start at zero after reset through per-entry valid
// bits, with no clearing pass.
module signed_key_counter_table (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  skct_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output skct_pkg::out_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [skct_pkg::IDX_W-1:0]  key_r;
  logic                        last_r;
  logic signed [15:0]          delta_r;
  logic signed [31:0]          now_r, now_nxt;
  logic [skct_pkg::IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [skct_pkg::IDX_W-1:0]  chk_idx_r;
  logic                        chk_vld_r;
  logic [skct_pkg::NPOS_W-1:0] npos_r;
  logic [skct_pkg::IDX_W-1:0]  maxkey_r;
  logic                        found_r;
  logic [30:0]                 best_r;
  logic [skct_pkg::NUM_KEYS-1:0] valid_r;

  logic                        in_xfer;
  logic                        in_range;
  logic                        out_free;

  logic                        ram_we;
  logic [skct_pkg::IDX_W-1:0]  ram_addr;
  logic [skct_pkg::CNT_W-1:0]  ram_wdata;
  logic [skct_pkg::CNT_W-1:0]  ram_rdata;

  logic signed [31:0]          upd_old;
  logic signed [32:0]          upd_sum;
  logic signed [31:0]          upd_sat;
  logic signed [31:0]          chk_val;
  logic                        chk_pos;

  skct_pkg::out_t              out_r;
  logic                        out_valid_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign in_range = (32'(in_data.key) < 32'(skct_pkg::NUM_KEYS));
  assign out_free = !out_valid_r || !out_stall;

  // Counter table
  skct_ram #(
    .WIDTH (skct_pkg::CNT_W),
    .DEPTH (skct_pkg::NUM_KEYS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Saturating add of the delta to the addressed counter
  always_comb begin
    upd_old = valid_r[key_r] ? $signed(ram_rdata) : 32'sd0;
    upd_sum = 33'(upd_old) + 33'(delta_r);
    priority if (upd_sum[32] != upd_sum[31]) begin
      upd_sat = upd_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      upd_sat = upd_sum[31:0];
    end
  end

  // Shared compare unit for the scan
  assign chk_val = valid_r[chk_idx_r] ? $signed(ram_rdata) : 32'sd0;
  assign chk_pos = !chk_val[31] && (chk_val != 32'sd0);

  // RAM port select
  always_comb begin
    ram_we    = (state_r == S_UPD);
    ram_wdata = upd_sat;
    unique case (state_r)
      S_IDLE:  ram_addr = skct_pkg::IDX_W'(in_data.key);
      S_UPD:   ram_addr = key_r;
      default: ram_addr = scan_idx_r;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    now_nxt      = now_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt    = in_range ? S_UPD : S_SCAN;
          scan_idx_nxt = '0;
          now_nxt      = 32'sd0;
        end
      end
      S_UPD: begin
        state_nxt = S_SCAN;
        now_nxt   = upd_sat;
      end
      S_SCAN: begin
        if (32'(scan_idx_r) == 32'(skct_pkg::NUM_KEYS - 1)) begin
          state_nxt = S_LAST;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      S_LAST: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= (state_r == S_SCAN);
      if (ram_we) begin
        valid_r[key_r] <= 1'b1;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold item fields and accumulate the scan
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    now_r      <= now_nxt;
    chk_idx_r  <= scan_idx_r;
    if (in_xfer) begin
      key_r    <= skct_pkg::IDX_W'(in_data.key);
      delta_r  <= in_data.delta;
      last_r   <= in_data.batch_last;
      npos_r   <= '0;
      maxkey_r <= '0;
      found_r  <= 1'b0;
      best_r   <= '0;
    end else if (chk_vld_r && chk_pos) begin
      npos_r   <= npos_r + 1'b1;
      maxkey_r <= chk_idx_r;
      found_r  <= 1'b1;
      if (chk_val[30:0] > best_r) begin
        best_r <= chk_val[30:0];
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_r.key_count        <= now_r;
      out_r.positive_keys    <= 9'(npos_r);
      out_r.any_positive     <= found_r;
      out_r.max_positive_key <= 8'(maxkey_r);
      out_r.max_count        <= best_r;
      out_r.batch_end        <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
